FILE: rtl/assert_macros.svh
// assertion macros for the checker file crs_checker.sv
// no dependencies; each macro wraps one concurrent assertion with a disable iff on reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define CRS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// next-cycle implication, disabled while reset is high
`define CRS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

FILE: rtl/crs_pkg.sv
// shared types and constants for the clip rectangle stack
// no dependencies; used by every module of the block
package crs_pkg;

   // default number of stack levels, level zero included
   localparam int STACK_DEPTH_DEF = 64;

   // width of the reported level field
   localparam int LEVEL_W = 6;

   // one rectangle, left bound in the lowest bits
   typedef struct packed {
      logic signed [15:0] bottom;
      logic signed [15:0] right;
      logic signed [15:0] top;
      logic signed [15:0] left;
   } rect_type;

   // screen range after reset
   localparam rect_type SCREEN_RESET = '{
      bottom: 16'sd32767,
      right:  16'sd32767,
      top:    16'sd0,
      left:   16'sd0
   };

   // command codes carried in the request tuser
   typedef enum logic [1:0] {
      CMD_PUSH  = 2'd0,
      CMD_POP   = 2'd1,
      CMD_RESET = 2'd2
   } cmd_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_LEFT   = 2'd0,
      CSR_TOP    = 2'd1,
      CSR_RIGHT  = 2'd2,
      CSR_BOTTOM = 2'd3
   } csr_idx_type;

   // control states
   typedef enum logic {
      ST_IDLE     = 1'b0,
      ST_POP_WAIT = 1'b1
   } state_type;

endpackage

FILE: rtl/crs_csr.sv
// screen range registers written through the configuration channel
// depends on crs_pkg
module crs_csr
   import crs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output rect_type    screen
);

   rect_type screen_ff;

   // writes are always taken
   assign csr_ready = 1'b1;
   assign screen    = screen_ff;

   // register file update on a write transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         screen_ff <= SCREEN_RESET;
      end else if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_LEFT:   screen_ff.left   <= csr_wdata;
            CSR_TOP:    screen_ff.top    <= csr_wdata;
            CSR_RIGHT:  screen_ff.right  <= csr_wdata;
            CSR_BOTTOM: screen_ff.bottom <= csr_wdata;
            default:    screen_ff        <= screen_ff;
         endcase
      end
   end

endmodule

FILE: rtl/crs_stack_ram.sv
// saved rectangle memory, one write and one read port, registered read data
// depends on crs_pkg
module crs_stack_ram
   import crs_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   localparam int AddrW = $clog2(STACK_DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  rect_type         wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output rect_type         rd_data
);

   rect_type mem_ram [STACK_DEPTH];
   rect_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ram[wr_addr] <= wr_data;
      end
   end

   // read port, read data registered while rd_en is high
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ram[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/crs_engine.sv
// command sequencer: current rectangle, nesting level, stack memory access
// and the registered response stage; depends on crs_pkg
module crs_engine
   import crs_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   localparam int LvlW = $clog2(STACK_DEPTH)
) (
   input  logic               clock,
   input  logic               reset,
   input  rect_type           screen,
   // request side
   input  logic               req_valid,
   output logic               req_ready,
   input  cmd_type            req_cmd,
   input  rect_type           req_rect,
   // response side
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rect_type           rsp_rect,
   output logic [LEVEL_W-1:0] rsp_level,
   output logic               rsp_ignored,
   // stack memory
   output logic               mem_wr_en,
   output logic [LvlW-1:0]    mem_wr_addr,
   output rect_type           mem_wr_data,
   output logic               mem_rd_en,
   output logic [LvlW-1:0]    mem_rd_addr,
   input  rect_type           mem_rd_data
);

   localparam logic [LvlW-1:0] LvlMax = LvlW'(STACK_DEPTH - 1);
   localparam logic [LvlW-1:0] LvlOne = LvlW'(1);

   state_type          state_ff, state_in;
   logic [LvlW-1:0]    level_ff, level_in;
   rect_type           cur_ff, cur_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rect_type           rsp_rect_ff;
   logic [LEVEL_W-1:0] rsp_level_ff;
   logic               rsp_ignored_ff;

   logic               accept;
   logic               load_out;
   rect_type           out_rect;
   logic               out_ignored;
   rect_type           shrunk;
   logic [LvlW+LEVEL_W-1:0] level_wide;

   // take a new item only when idle and the response slot frees up
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   // intersection of current rectangle with the pushed one
   always_comb begin
      shrunk.left   = (cur_ff.left > req_rect.left)     ? cur_ff.left   : req_rect.left;
      shrunk.top    = (cur_ff.top > req_rect.top)       ? cur_ff.top    : req_rect.top;
      shrunk.right  = (cur_ff.right < req_rect.right)   ? cur_ff.right  : req_rect.right;
      shrunk.bottom = (cur_ff.bottom < req_rect.bottom) ? cur_ff.bottom : req_rect.bottom;
   end

   // next state, memory access and response load
   always_comb begin
      state_in    = state_ff;
      level_in    = level_ff;
      cur_in      = cur_ff;
      load_out    = 1'b0;
      out_rect    = cur_ff;
      out_ignored = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = level_ff + LvlOne;
      mem_wr_data = shrunk;
      mem_rd_en   = 1'b0;
      mem_rd_addr = level_ff - LvlOne;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  CMD_PUSH: begin
                     load_out = 1'b1;
                     if (level_ff >= LvlMax) begin
                        out_ignored = 1'b1;
                     end else begin
                        mem_wr_en = 1'b1;
                        level_in  = level_ff + LvlOne;
                        cur_in    = shrunk;
                        out_rect  = shrunk;
                     end
                  end
                  CMD_POP: begin
                     if (level_ff == '0) begin
                        load_out    = 1'b1;
                        out_ignored = 1'b1;
                     end else if (level_ff == LvlOne) begin
                        // back to the screen range as it stands now
                        load_out = 1'b1;
                        level_in = '0;
                        cur_in   = screen;
                        out_rect = screen;
                     end else begin
                        // saved rectangle arrives next cycle
                        mem_rd_en = 1'b1;
                        level_in  = level_ff - LvlOne;
                        state_in  = ST_POP_WAIT;
                     end
                  end
                  CMD_RESET: begin
                     load_out = 1'b1;
                     level_in = '0;
                     cur_in   = screen;
                     out_rect = screen;
                  end
                  default: begin
                     load_out = 1'b1;
                  end
               endcase
            end
         end
         ST_POP_WAIT: begin
            load_out = 1'b1;
            cur_in   = mem_rd_data;
            out_rect = mem_rd_data;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = load_out || (rsp_valid_ff && !rsp_ready);
   end

   // level reported as its low bits, zero extended for shallow stacks
   assign level_wide = {{LEVEL_W{1'b0}}, level_in};

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         level_ff     <= '0;
         cur_ff       <= SCREEN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_rect_ff    <= out_rect;
         rsp_level_ff   <= level_wide[LEVEL_W-1:0];
         rsp_ignored_ff <= out_ignored;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_rect    = rsp_rect_ff;
   assign rsp_level   = rsp_level_ff;
   assign rsp_ignored = rsp_ignored_ff;

endmodule

FILE: rtl/clip_rectangle_stack_core.sv
// Push, reset, no-op, pop to level zero and ignored pop: response registered in the cycle
// after the transfer, one item per cycle sustained while the response is taken. Pop to
// level one or deeper: the saved rectangle is read into the memory's registered output,
// then registered as the response; input held off in between.
// Reset: level zero, screen range registers and current rectangle at their reset
// values, response empty; the stack memory is not cleared (entries are written by push).
module clip_rectangle_stack_core
   import crs_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request: command and rectangle
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // rect_left, rect_top, rect_right, rect_bottom
   input  logic [1:0]  req_tuser,  // command
   // response: current clip rectangle
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // clip_left, clip_top, clip_right, clip_bottom,
                                   // level, zero pad
   output logic [0:0]  rsp_tuser,  // ignored
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int LvlW = $clog2(STACK_DEPTH);

   rect_type           screen;
   rect_type           rsp_rect;
   logic [LEVEL_W-1:0] rsp_level;
   logic               rsp_ignored;
   logic               mem_wr_en;
   logic [LvlW-1:0]    mem_wr_addr;
   rect_type           mem_wr_data;
   logic               mem_rd_en;
   logic [LvlW-1:0]    mem_rd_addr;
   rect_type           mem_rd_data;

   // screen range registers
   crs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .screen    (screen)
   );

   // saved rectangles
   crs_stack_ram #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // command sequencer
   crs_engine #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .screen      (screen),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_cmd     (cmd_type'(req_tuser)),
      .req_rect    (rect_type'(req_tdata)),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_rect    (rsp_rect),
      .rsp_level   (rsp_level),
      .rsp_ignored (rsp_ignored),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // response packing
   assign rsp_tdata = {2'b00, rsp_level, rsp_rect};
   assign rsp_tuser = rsp_ignored;

endmodule

FILE: rtl/crs_checker.sv
// port-level checks for the clip rectangle stack, bound to the top level
// depends on crs_pkg and assert_macros.svh
`include "assert_macros.svh"

module crs_checker
   import crs_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   localparam logic [LEVEL_W-1:0] LvlTop = LEVEL_W'(STACK_DEPTH - 1);

   // a stalled response holds its payload
   `CRS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // no request transfer while the response slot stays occupied
   `CRS_ASSERT_SAME(a_no_overrun, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)

   // reset command answers next cycle at level zero, not ignored
   `CRS_ASSERT_NEXT(a_reset_cmd, clock, reset, req_tvalid && req_tready && (req_tuser == CMD_RESET), rsp_tvalid && (rsp_tdata[69:64] == '0) && !rsp_tuser[0])

   // an ignored command is only possible at the bottom or the top of the stack
   `CRS_ASSERT_SAME(a_ignored_level, clock, reset, rsp_tvalid && rsp_tuser[0], (rsp_tdata[69:64] == '0) || (rsp_tdata[69:64] == LvlTop))

endmodule

bind clip_rectangle_stack_core crs_checker #(
   .STACK_DEPTH (STACK_DEPTH)
) u_crs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: bench/clip_rectangle_stack_core_tb.sv
// self-checking bench for clip_rectangle_stack_core: nested clip push, pop and reset
// depends on crs_pkg for the rectangle type, command codes and register indexes
module clip_rectangle_stack_core_tb
   import crs_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STACK_DEPTH = STACK_DEPTH_DEF;
   localparam int RUN_LIMIT = 400000;
   localparam int ITEMS_PER_PHASE = 200;
   localparam int PHASES = 8;
   localparam int LONG_HOLD_CYCLES = 400;

   // unused command value, reported as a no-op
   localparam logic [1:0] CMD_NOP = 2'd3;

   // one expected transfer on the response channel
   typedef struct packed {
      rect_type   clip;
      logic [5:0] level;
      logic       ignored;
   } clip_report_type;

   // directed stimulus row; typed rows carry their expected report
   typedef struct packed {
      logic [1:0] cmd;
      int         rl;
      int         rt;
      int         rr;
      int         rb;
      bit         typed;
      int         cl;
      int         ct;
      int         cr;
      int         cb;
      int         lvl;
      bit         ign;
   } directed_row_type;

   localparam directed_row_type DIRECTED_ROWS [21] = '{
      '{CMD_POP,   0, 0, 0, 0,                       1, 0, 0, 32767, 32767, 0, 1},
      '{CMD_NOP,   1234, -5678, 4321, -8765,         1, 0, 0, 32767, 32767, 0, 0},
      '{CMD_PUSH,  -32768, -32768, 32767, 32767,     1, 0, 0, 32767, 32767, 1, 0},
      '{CMD_PUSH,  100, 200, 300, 400,               1, 100, 200, 300, 400, 2, 0},
      '{CMD_PUSH,  -32768, 32767, -32768, 32767,     1, 100, 32767, -32768, 400, 3, 0},
      '{CMD_PUSH,  0, 0, 0, 0,                       1, 100, 32767, -32768, 0, 4, 0},
      '{CMD_NOP,   -1, -1, -1, -1,                   1, 100, 32767, -32768, 0, 4, 0},
      '{CMD_POP,   0, 0, 0, 0,                       0, 0, 0, 0, 0, 0, 0},
      '{CMD_POP,   -1, -1, -1, -1,                   0, 0, 0, 0, 0, 0, 0},
      '{CMD_PUSH,  32767, -32768, 32767, -32768,     1, 32767, 200, 300, -32768, 3, 0},
      '{CMD_POP,   0, 0, 0, 0,                       0, 0, 0, 0, 0, 0, 0},
      '{CMD_POP,   0, 0, 0, 0,                       0, 0, 0, 0, 0, 0, 0},
      '{CMD_POP,   0, 0, 0, 0,                       1, 0, 0, 32767, 32767, 0, 0},
      '{CMD_POP,   0, 0, 0, 0,                       1, 0, 0, 32767, 32767, 0, 1},
      '{CMD_PUSH,  -1, -1, -1, -1,                   1, 0, 0, -1, -1, 1, 0},
      '{CMD_PUSH,  1, 1, 1, 1,                       1, 1, 1, -1, -1, 2, 0},
      '{CMD_RESET, 5, 6, 7, 8,                       1, 0, 0, 32767, 32767, 0, 0},
      '{CMD_RESET, -32768, -32768, -32768, -32768,   1, 0, 0, 32767, 32767, 0, 0},
      '{CMD_PUSH,  32767, 32767, 32767, 32767,       1, 32767, 32767, 32767, 32767, 1, 0},
      '{CMD_PUSH,  -32768, -32768, -32768, -32768,   1, 32767, 32767, -32768, -32768, 2, 0},
      '{CMD_RESET, 0, 0, 0, 0,                       1, 0, 0, 32767, 32767, 0, 0}
   };

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;  // rect_left, rect_top, rect_right, rect_bottom
   logic [1:0]  req_tuser = '0;  // command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;       // clip_left, clip_top, clip_right, clip_bottom, level, pad
   logic [0:0]  rsp_tuser;       // ignored
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   // predicted block state
   rect_type    screen_range = SCREEN_RESET;
   rect_type    current_clip = SCREEN_RESET;
   int unsigned clip_depth = 0;
   rect_type    saved_clips [STACK_DEPTH];

   clip_report_type expected_clips [$];
   int          clip_errors = 0;
   int          cycle_count = 0;
   int          burst_left = 0;
   logic        long_hold_req = 1'b0;
   int          hold_cycles = 0;
   int          ready_stretch = 0;
   int          ready_mode = 0;

   clip_rectangle_stack_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic rect_type make_rect(int l, int t, int r, int b);
      rect_type x;
      x.left   = 16'(l);
      x.top    = 16'(t);
      x.right  = 16'(r);
      x.bottom = 16'(b);
      return x;
   endfunction

   // clip stack step: intersect on push, restore on pop, screen range on reset
   function automatic clip_report_type clip_step(logic [1:0] cmd, rect_type area);
      clip_report_type rep;
      rect_type        inner;
      rep.ignored = 1'b0;
      case (cmd)
         CMD_PUSH: begin
            if (clip_depth >= STACK_DEPTH - 1) begin
               rep.ignored = 1'b1;
            end else begin
               inner.left   = (area.left > current_clip.left) ? area.left : current_clip.left;
               inner.top    = (area.top > current_clip.top) ? area.top : current_clip.top;
               inner.right  = (area.right < current_clip.right) ? area.right : current_clip.right;
               inner.bottom = (area.bottom < current_clip.bottom) ?
                              area.bottom : current_clip.bottom;
               clip_depth++;
               saved_clips[clip_depth] = inner;
               current_clip = inner;
            end
         end
         CMD_POP: begin
            if (clip_depth == 0) begin
               rep.ignored = 1'b1;
            end else begin
               clip_depth--;
               // level zero always reloads the screen range as currently programmed
               current_clip = (clip_depth == 0) ? screen_range : saved_clips[clip_depth];
            end
         end
         CMD_RESET: begin
            clip_depth = 0;
            current_clip = screen_range;
         end
         default: ;
      endcase
      rep.clip  = current_clip;
      rep.level = 6'(clip_depth);
      return rep;
   endfunction

   function automatic logic signed [15:0] pick_extreme();
      case ($urandom_range(0, 4))
         0: return -16'sd32768;
         1: return -16'sd1;
         2: return 16'sd0;
         3: return 16'sd1;
         default: return 16'sd32767;
      endcase
   endfunction

   // move a bound mostly inward (dir +1 for left/top, -1 for right/bottom), clamped
   function automatic logic signed [15:0] nudge(logic signed [15:0] bound, int dir);
      int v;
      v = int'(bound) + dir * (int'($urandom_range(0, 250)) - 50);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return 16'(v);
   endfunction

   function automatic rect_type pick_rect();
      rect_type x;
      int       sel;
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
         x.left   = nudge(current_clip.left, 1);
         x.top    = nudge(current_clip.top, 1);
         x.right  = nudge(current_clip.right, -1);
         x.bottom = nudge(current_clip.bottom, -1);
      end else if (sel < 8) begin
         x = rect_type'({$urandom(), $urandom()});
      end else begin
         x.left   = pick_extreme();
         x.top    = pick_extreme();
         x.right  = pick_extreme();
         x.bottom = pick_extreme();
      end
      return x;
   endfunction

   function automatic void note_error(string msg);
      clip_errors++;
      if (clip_errors <= 10)
         $display("clip check error at %0t: %s", $time, msg);
   endfunction

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want)
         note_error($sformatf("%s expected %0d got %0d", name, $signed(want), $signed(got)));
   endfunction

   // one request transfer, sender idles in bursts
   task automatic drive_request(logic [1:0] cmd, rect_type area);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if ($urandom_range(0, 15) == 0) gap = $urandom_range(10, 30);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= area;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_clip(logic [1:0] cmd, rect_type area);
      drive_request(cmd, area);
      expected_clips.push_back(clip_step(cmd, area));
   endtask

   // stop offering and wait for every outstanding result
   task automatic drain_clips();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (expected_clips.size() != 0) @(posedge clock);
   endtask

   // program the screen range, one transfer per register
   task automatic write_screen(rect_type s);
      csr_idx_type order [4];
      logic [15:0] vals [4];
      order = '{CSR_LEFT, CSR_TOP, CSR_RIGHT, CSR_BOTTOM};
      vals  = '{s.left, s.top, s.right, s.bottom};
      for (int i = 0; i < 4; i++) begin
         @(negedge clock);
         csr_valid <= 1'b1;
         csr_index <= order[i];
         csr_wdata <= vals[i];
         do @(posedge clock); while (!csr_ready);
         case (order[i])
            CSR_LEFT:   screen_range.left   = vals[i];
            CSR_TOP:    screen_range.top    = vals[i];
            CSR_RIGHT:  screen_range.right  = vals[i];
            CSR_BOTTOM: screen_range.bottom = vals[i];
         endcase
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // receiver stall pattern, plus long hold-off on request
   always @(negedge clock) begin
      if (long_hold_req) begin
         hold_cycles = LONG_HOLD_CYCLES;
         long_hold_req = 1'b0;
      end
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_tready <= 1'b0;
      end else begin
         if (ready_stretch == 0) begin
            ready_mode = $urandom_range(0, 3);
            ready_stretch = $urandom_range(10, 150);
         end
         ready_stretch--;
         case (ready_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= ~rsp_tready;
         endcase
      end
   end

   // compare each response transfer with the oldest prediction
   always @(posedge clock) begin : check_rsp
      clip_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_clips.size() == 0) begin
            note_error($sformatf("unexpected result data %h flag %b", rsp_tdata, rsp_tuser));
         end else begin
            want = expected_clips.pop_front();
            check_field("clip_left", want.clip.left, rsp_tdata[15:0]);
            check_field("clip_top", want.clip.top, rsp_tdata[31:16]);
            check_field("clip_right", want.clip.right, rsp_tdata[47:32]);
            check_field("clip_bottom", want.clip.bottom, rsp_tdata[63:48]);
            check_field("level", 16'(want.level), 16'(rsp_tdata[69:64]));
            check_field("ignored", 16'(want.ignored), 16'(rsp_tuser[0]));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= RUN_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin : stimulus
      directed_row_type row;
      clip_report_type  pred;
      rect_type         area;
      rect_type         screen;
      int               sent;
      int               seg;
      int               n;
      int               pick;
      bit               first_seg;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows against the reset screen range
      foreach (DIRECTED_ROWS[i]) begin
         row  = DIRECTED_ROWS[i];
         area = make_rect(row.rl, row.rt, row.rr, row.rb);
         drive_request(row.cmd, area);
         pred = clip_step(row.cmd, area);
         if (row.typed) begin
            pred.clip    = make_rect(row.cl, row.ct, row.cr, row.cb);
            pred.level   = 6'(row.lvl);
            pred.ignored = row.ign;
         end
         expected_clips.push_back(pred);
      end

      // random phases, each with its own screen range
      for (int phase = 1; phase <= PHASES; phase++) begin
         drain_clips();
         case (phase)
            1: screen = make_rect(-32768, -32768, 32767, 32767);
            2: screen = make_rect(32767, 32767, -32768, -32768);
            3: screen = make_rect(-32768, -32768, -32768, -32768);
            4: screen = make_rect(32767, 32767, 32767, 32767);
            5: screen = make_rect(-100, -50, 100, 50);
            default: screen = rect_type'({$urandom(), $urandom()});
         endcase
         write_screen(screen);
         // without a reset command the old stack stays, and a pop to level zero
         // picks up the new range
         if ($urandom_range(0, 1) == 1)
            send_clip(CMD_RESET, rect_type'({$urandom(), $urandom()}));
         if (phase == 2)
            long_hold_req = 1'b1;

         sent = 0;
         first_seg = 1'b1;
         while (sent < ITEMS_PER_PHASE) begin
            seg = first_seg ? 0 : $urandom_range(0, 9);
            first_seg = 1'b0;
            if (seg <= 3) begin
               // dive: nested pushes, often past full stack, then partial unwind
               n = (seg == 0) ? 70 : $urandom_range(5, 70);
               repeat (n) send_clip(CMD_PUSH, pick_rect());
               sent += n;
               n = $urandom_range(0, n);
               repeat (n) send_clip(CMD_POP, rect_type'({$urandom(), $urandom()}));
               sent += n;
            end else if (seg == 4) begin
               // unwind to level zero, with up to three extra pops beyond it
               n = clip_depth + $urandom_range(0, 3);
               repeat (n) send_clip(CMD_POP, rect_type'({$urandom(), $urandom()}));
               sent += n;
            end else begin
               // mixed commands
               n = $urandom_range(10, 40);
               repeat (n) begin
                  pick = $urandom_range(0, 99);
                  if (pick < 40)
                     send_clip(CMD_PUSH, pick_rect());
                  else if (pick < 80)
                     send_clip(CMD_POP, rect_type'({$urandom(), $urandom()}));
                  else if (pick < 90)
                     send_clip(CMD_RESET, rect_type'({$urandom(), $urandom()}));
                  else
                     send_clip(CMD_NOP, rect_type'({$urandom(), $urandom()}));
               end
               sent += n;
            end
         end
      end

      drain_clips();
      repeat (20) @(posedge clock);
      if (clip_errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/crs_pkg.sv
rtl/crs_csr.sv
rtl/crs_stack_ram.sv
rtl/crs_engine.sv
rtl/clip_rectangle_stack_core.sv
rtl/crs_checker.sv
bench/clip_rectangle_stack_core_tb.sv
